>>> hdl/bsm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the binomial 3x3 smoothing block.
// No dependencies; imported by every module of the block.

package bsm_pkg;

	// Default geometry and sample size
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// Configuration register fields
	localparam int GW_BITS       = 11;
	localparam int GH_BITS       = 13;
	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_IDX_BITS  = 2;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int RESET_DIM     = 1024;

	// Result coordinate fields
	localparam int COL_BITS = 10;
	localparam int ROW_BITS = 12;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	// Position of one result cell and which neighbor taps lie in the grid
	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                last;
		logic                left;
		logic                right;
		logic                up;
		logic                down;
	} meta_t;

endpackage

>>> hdl/bsm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on bsm_pkg for parameter defaults only.

module bsm_ram import bsm_pkg::*; #(
	parameter int WIDTH = 2 * DEF_SAMPLE_BITS,
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/bsm_cell.sv
`timescale 1ns / 1ps
// One column of the 3x3 window: top, middle and bottom taps.
// Loads its neighbor's column on each shift. Depends on bsm_pkg.

module bsm_cell import bsm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  logic [2:0][SAMPLE_BITS-1:0] din,
	output logic [2:0][SAMPLE_BITS-1:0] dout
);

	logic [2:0][SAMPLE_BITS-1:0] col_q;

	// column register, moves one place left per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;

endmodule

>>> hdl/bsm_kernel.sv
`timescale 1ns / 1ps
// Weighted 1-2-1 window sum and divide by the in-grid weight total.
// Four stages: sum, reciprocal multiply, correction, output register. Depends on bsm_pkg.

module bsm_kernel import bsm_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	output logic                             free,
	input  logic [2:0][2:0][SAMPLE_BITS-1:0] win,
	input  meta_t                            meta,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [SAMPLE_BITS-1:0]           smoothed,
	output logic [COL_BITS-1:0]              col,
	output logic [ROW_BITS-1:0]              row,
	output logic                             frame_end
);

	// sum of weights is at most 16
	localparam int DW = SAMPLE_BITS + 4;
	localparam int PRW = 2 * DW;
	localparam logic [DW-1:0] RECIP3 = DW'(((DW + 1)'(1) << DW) / 3);
	localparam logic [DW-1:0] RECIP9 = DW'(((DW + 1)'(1) << DW) / 9);
	localparam logic [DW-1:0] K3 = DW'(3);
	localparam logic [DW-1:0] K9 = DW'(9);

	typedef enum logic [1:0] {
		DIV_POW2,
		DIV_THREE,
		DIV_NINE
	} div_kind_t;

	logic v_s2, v_s3, v_s4, v_s5;
	logic free_s3, free_s4, take_s5;
	meta_t meta_s2, meta_s3, meta_s4, meta_s5;

	logic [2:0]    in_x, in_y;
	logic [1:0]    ax, ay, threes;
	logic [2:0]    sh;
	logic [DW-1:0] sum;
	div_kind_t     kind;

	logic [DW-1:0]  sum_s3;
	logic [2:0]     sh_s3;
	div_kind_t      kind_s3;
	logic [DW-1:0]  d3;
	logic [PRW-1:0] prod;

	logic [PRW-1:0] prod_s4;
	logic [DW-1:0]  d_s4;
	div_kind_t      kind_s4;
	logic [DW-1:0]  q0, kq, kdiv, rem, quot;

	logic [SAMPLE_BITS-1:0] quot_s5;

	// backpressure chain, bubbles collapse
	assign take_s5 = !v_s5 || out_ready;
	assign free_s4 = !v_s4 || take_s5;
	assign free_s3 = !v_s3 || free_s4;
	assign free    = !v_s2 || free_s3;

	// s2: weighted sum of in-grid taps and divisor decode
	always_comb begin
		in_x = {meta_s2.right, 1'b1, meta_s2.left};
		in_y = {meta_s2.down, 1'b1, meta_s2.up};
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (in_x[c] && in_y[r]) begin
					sum = sum + (DW'(win[c][r]) << (((c == 1) ? 1 : 0) + ((r == 1) ? 1 : 0)));
				end
			end
		end
		// axis weight total: 2, 3 or 4
		ax = 2'(meta_s2.left) + 2'(meta_s2.right);
		ay = 2'(meta_s2.up) + 2'(meta_s2.down);
		sh = 3'((ax == 2'd2) ? 2 : ((ax == 2'd0) ? 1 : 0))
			+ 3'((ay == 2'd2) ? 2 : ((ay == 2'd0) ? 1 : 0));
		threes = 2'(ax == 2'd1) + 2'(ay == 2'd1);
		case (threes)
			2'd0:    kind = DIV_POW2;
			2'd1:    kind = DIV_THREE;
			default: kind = DIV_NINE;
		endcase
	end

	// s3: strip power of two, multiply by reciprocal
	assign d3 = sum_s3 >> sh_s3;
	assign prod = PRW'(d3) * PRW'((kind_s3 == DIV_NINE) ? RECIP9 : RECIP3);

	// s4: estimate is exact or one low; fix with one compare
	always_comb begin
		q0 = prod_s4[PRW-1:DW];
		case (kind_s4)
			DIV_THREE: begin
				kq   = q0 + (q0 << 1);
				kdiv = K3;
			end
			DIV_NINE: begin
				kq   = q0 + (q0 << 3);
				kdiv = K9;
			end
			default: begin
				kq   = '0;
				kdiv = K3;
			end
		endcase
		rem = d_s4 - kq;
		if (kind_s4 == DIV_POW2) begin
			quot = d_s4;
		end else if (rem >= kdiv) begin
			quot = q0 + DW'(1);
		end else begin
			quot = q0;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (free) begin
				v_s2 <= load;
			end
			if (free_s3) begin
				v_s3 <= v_s2;
			end
			if (free_s4) begin
				v_s4 <= v_s3;
			end
			if (take_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (free && load) begin
			meta_s2 <= meta;
		end
		if (free_s3 && v_s2) begin
			sum_s3  <= sum;
			sh_s3   <= sh;
			kind_s3 <= kind;
			meta_s3 <= meta_s2;
		end
		if (free_s4 && v_s3) begin
			prod_s4 <= prod;
			d_s4    <= d3;
			kind_s4 <= kind_s3;
			meta_s4 <= meta_s3;
		end
		if (take_s5 && v_s4) begin
			quot_s5 <= SAMPLE_BITS'(quot);
			meta_s5 <= meta_s4;
		end
	end

	assign out_valid = v_s5;
	assign smoothed  = quot_s5;
	assign col       = meta_s5.col;
	assign row       = meta_s5.row;
	assign frame_end = meta_s5.last;

endmodule

>>> hdl/binomial_3x3_smooth_top.sv
`timescale 1ns / 1ps
// Top level of the binomial 3x3 smoothing block: geometry registers, raster
// counters, line store, window cells. Depends on bsm_pkg, bsm_ram, bsm_cell, bsm_kernel.

// Channel  Handshake                 Payload
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
// in       in_valid / in_ready       sample, pad
// out      out_valid / out_ready     smoothed, col, row, frame_end
//
// One beat per clock sustained while out_ready is high. A result is offered once
// the beat that completes its window is accepted and has gone through the line
// store read on that edge, then window shift, sum, multiply and correct.
// The line store is one RAM read and written once per beat; a read of the
// column written on the same edge is forwarded. Async reset clears counters, window
// and pipeline valids; the line store is not cleared. A low out_ready holds
// the output register; in_ready drops only once every stage is full.

module binomial_3x3_smooth_top import bsm_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic                     pad,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SAMPLE_BITS-1:0]   smoothed,
	output logic [COL_BITS-1:0]      col,
	output logic [ROW_BITS-1:0]      row,
	output logic                     frame_end
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = WW + GH_BITS;
	localparam int RAM_W = 2 * SAMPLE_BITS;

	function automatic int unsigned clamp_dim(int unsigned raw, int unsigned lim);
		int unsigned d;
		d = raw;
		if (d == 0) begin
			d = 1;
		end
		if (d > lim) begin
			d = lim;
		end
		return d;
	endfunction

	localparam logic [WW-1:0]      RST_W = WW'(clamp_dim(RESET_DIM, MAX_WIDTH));
	localparam logic [GH_BITS-1:0] RST_H = GH_BITS'(clamp_dim(RESET_DIM, HEIGHT_LIMIT));
	localparam logic [PW-1:0]      RST_TOTAL = PW'(RST_W) * PW'(RST_H);

	logic [WW-1:0]      eff_w_q, nxt_w;
	logic [GH_BITS-1:0] eff_h_q, nxt_h;
	logic [PW-1:0]      total_q, pos_q;
	logic [XW-1:0]      in_col_q, ocol_q;
	logic [ROW_BITS-1:0] orow_q;
	logic cfg_acc, cfg_restart;

	logic in_acc, in_frame, take, emit, col_wrap, last_col, last_row;
	logic [SAMPLE_BITS-1:0] v_in;
	meta_t meta_in;

	logic v_s1, emit_s1, fwd_s1, free_s1, mv_s1, k_free;
	logic [SAMPLE_BITS-1:0] samp_s1, mid, top;
	logic [XW-1:0]          addr_s1;
	meta_t                  meta_s1;
	logic [RAM_W-1:0]       fwd_pair_s1, ram_rd, line_pair;

	logic [3:0][2:0][SAMPLE_BITS-1:0] chain;

	// configuration writes, clamped to the supported geometry
	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid & cfg_ready;

	always_comb begin
		nxt_w = eff_w_q;
		nxt_h = eff_h_q;
		cfg_restart = 1'b0;
		if (cfg_acc) begin
			case (cfg_index)
				REG_GRID_WIDTH: begin
					nxt_w = WW'(clamp_dim(32'(cfg_data[GW_BITS-1:0]), MAX_WIDTH));
					cfg_restart = 1'b1;
				end
				REG_GRID_HEIGHT: begin
					nxt_h = GH_BITS'(clamp_dim(32'(cfg_data[GH_BITS-1:0]), HEIGHT_LIMIT));
					cfg_restart = 1'b1;
				end
				default: begin
					cfg_restart = 1'b0;
				end
			endcase
		end
	end

	// input beat decode
	assign free_s1  = !v_s1 || k_free;
	assign mv_s1    = v_s1 && k_free;
	assign in_ready = free_s1;
	assign in_acc   = in_valid & in_ready;
	assign in_frame = pos_q < total_q;
	// a pad inside the frame is dropped
	assign take     = in_acc & ~(in_frame & pad);
	assign v_in     = in_frame ? sample : '0;
	// results trail the input by one row plus one cell
	assign emit     = pos_q > PW'(eff_w_q);
	assign col_wrap = (WW'(in_col_q) + WW'(1)) >= eff_w_q;
	assign last_col = (WW'(ocol_q) + WW'(1)) == eff_w_q;
	assign last_row = (GH_BITS'(orow_q) + GH_BITS'(1)) == eff_h_q;

	always_comb begin
		meta_in.col   = COL_BITS'(ocol_q);
		meta_in.row   = orow_q;
		meta_in.last  = last_col & last_row;
		meta_in.left  = ocol_q != '0;
		meta_in.right = !last_col;
		meta_in.up    = orow_q != '0;
		meta_in.down  = !last_row;
	end

	// geometry, raster and result position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q  <= RST_W;
			eff_h_q  <= RST_H;
			total_q  <= RST_TOTAL;
			pos_q    <= '0;
			in_col_q <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else begin
			eff_w_q <= nxt_w;
			eff_h_q <= nxt_h;
			total_q <= PW'(nxt_w) * PW'(nxt_h);
			if (cfg_restart || (take && emit && meta_in.last)) begin
				pos_q    <= '0;
				in_col_q <= '0;
				ocol_q   <= '0;
				orow_q   <= '0;
			end else if (take) begin
				pos_q    <= pos_q + PW'(1);
				in_col_q <= col_wrap ? '0 : in_col_q + XW'(1);
				if (emit) begin
					if (last_col) begin
						ocol_q <= '0;
						orow_q <= orow_q + ROW_BITS'(1);
					end else begin
						ocol_q <= ocol_q + XW'(1);
					end
				end
			end
		end
	end

	// s1: line store data, forwarded when the previous beat wrote the same column
	assign line_pair = fwd_s1 ? fwd_pair_s1 : ram_rd;
	assign mid = line_pair[RAM_W-1:SAMPLE_BITS];
	assign top = line_pair[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= take;
			end
			if (take) begin
				fwd_s1 <= mv_s1 && (addr_s1 == in_col_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			samp_s1     <= v_in;
			addr_s1     <= in_col_q;
			emit_s1     <= emit;
			meta_s1     <= meta_in;
			fwd_pair_s1 <= {samp_s1, mid};
		end
	end

	// both line stores in one word: {previous row, row before that}
	bsm_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (mv_s1),
		.waddr (addr_s1),
		.wdata ({samp_s1, mid}),
		.re    (take),
		.raddr (in_col_q),
		.rdata (ram_rd)
	);

	// window: three column cells, newest on the right
	assign chain[3] = {samp_s1, mid, top};

	for (genvar c = 0; c < 3; c++) begin : g_cell
		bsm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (mv_s1),
			.din    (chain[c+1]),
			.dout   (chain[c])
		);
	end

	bsm_kernel #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (mv_s1 & emit_s1),
		.free      (k_free),
		.win       (chain[2:0]),
		.meta      (meta_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.smoothed  (smoothed),
		.col       (col),
		.row       (row),
		.frame_end (frame_end)
	);

endmodule
